[sv/multi_waveform_tone_oscillator_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the multi-waveform tone oscillator
// Immediate-implication and next-cycle-implication checks. Defining
// NO_ASSERTIONS removes every check.
// ----------------------------------------------------------------------------
`ifndef MULTI_WAVEFORM_TONE_OSCILLATOR_ASSERT_SVH
`define MULTI_WAVEFORM_TONE_OSCILLATOR_ASSERT_SVH

`ifndef NO_ASSERTIONS

// The consequent must hold in the same cycle as the antecedent.
`define MWTO_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mwto: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define MWTO_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mwto: next-cycle check failed");

`else

`define MWTO_ASSERT_SAME(label, clk, rst, ante, cons)
`define MWTO_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

[sv/mwto_pkg.sv]
// ----------------------------------------------------------------------------
// mwto_pkg
// Shared widths, codes, stage types and the quarter-sine table generator.
// ----------------------------------------------------------------------------
package mwto_pkg;

  // Default values of the top-level parameters.
  localparam int PHASE_BITS_DEF      = 32;
  localparam int TABLE_ADDR_BITS_DEF = 8;
  localparam int SAMPLE_BITS_DEF     = 16;
  localparam int COUNT_BITS_DEF      = 24;

  // Fixed register and field widths.
  localparam int STEP_W      = 32;
  localparam int AMP_W       = 15;
  localparam int NOTE_W      = 24;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_INDEX_W = 2;
  localparam int SINE_W      = 15;
  localparam int WAVE_W      = 16;
  localparam int PROD_W      = 31;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PHASE_STEP  = 2'd0,
    REG_AMPLITUDE   = 2'd1,
    REG_WAVEFORM    = 2'd2,
    REG_NOTE_FRAMES = 2'd3
  } cfg_index_t;

  // Waveform codes.
  typedef enum logic [1:0] {
    WAVE_SINE     = 2'd0,
    WAVE_SQUARE   = 2'd1,
    WAVE_SAW      = 2'd2,
    WAVE_TRIANGLE = 2'd3
  } wave_t;

  // Phase stage to shaper: one sample whose table read is in flight.
  typedef struct packed {
    logic              valid;
    logic [1:0]        quad;
    logic [WAVE_W-1:0] p16;
    logic              last;
  } mwto_tap_t;

  // Fixed-point constants of the table generator.
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] Q30_ONE     = 64'd1 << 30;

  // One step of the Taylor product: t = 1 - x2 * t / d, floored at zero.
  function automatic logic [63:0] taylor_keep(input logic [63:0] term);
    taylor_keep = (term >= Q30_ONE) ? 64'd0 : Q30_ONE - term;
  endfunction

  // Entry idx of the quarter-wave table, sampled at bin centers in Q30.
  function automatic logic [SINE_W-1:0] sine_entry(input int unsigned idx,
                                                   input int unsigned addr_bits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] e;
    x  = (HALF_PI_Q30 * (64'(idx) * 64'd2 + 64'd1)) >> (addr_bits + 1);
    x2 = (x * x) >> 30;
    t  = Q30_ONE;
    t  = taylor_keep(((x2 * t) >> 30) / 64'd156);
    t  = taylor_keep(((x2 * t) >> 30) / 64'd110);
    t  = taylor_keep(((x2 * t) >> 30) / 64'd72);
    t  = taylor_keep(((x2 * t) >> 30) / 64'd42);
    t  = taylor_keep(((x2 * t) >> 30) / 64'd20);
    t  = taylor_keep(((x2 * t) >> 30) / 64'd6);
    s  = (x * t) >> 30;
    e  = (s * 64'd32767 + (64'd1 << 29)) >> 30;
    sine_entry = (e > 64'd32767) ? 15'h7fff : e[SINE_W-1:0];
  endfunction

endpackage

[sv/mwto_ram.sv]
// ----------------------------------------------------------------------------
// mwto_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module mwto_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read data holds until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[sv/mwto_phase.sv]
// ----------------------------------------------------------------------------
// mwto_phase
// Phase accumulator, frame counter, table read issue and table fill sweep.
// ----------------------------------------------------------------------------
`include "multi_waveform_tone_oscillator_assert.svh"

module mwto_phase
  import mwto_pkg::*;
#(
  parameter int PHASE_BITS      = PHASE_BITS_DEF,
  parameter int TABLE_ADDR_BITS = TABLE_ADDR_BITS_DEF,
  parameter int COUNT_BITS      = COUNT_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       start_req,
  input  logic [STEP_W-1:0]          phase_step,
  input  logic [NOTE_W-1:0]          note_frames,
  input  logic                       st2_ready,
  output mwto_tap_t                  tap,
  output logic                       ram_we,
  output logic [TABLE_ADDR_BITS-1:0] ram_waddr,
  output logic [SINE_W-1:0]          ram_wdata,
  output logic                       ram_re,
  output logic [TABLE_ADDR_BITS-1:0] ram_raddr
);

  localparam int TBL_N = 1 << TABLE_ADDR_BITS;

  logic [PHASE_BITS-1:0]      phase_acc;
  logic [COUNT_BITS-1:0]      frames_left;
  logic [PHASE_BITS-1:0]      phase_eff;
  logic [COUNT_BITS-1:0]      frames_eff;
  logic [PHASE_BITS-1:0]      step_ext;
  logic                       produce;
  logic                       accept;
  logic                       s1_free;
  logic                       fill_done;
  logic [TABLE_ADDR_BITS-1:0] fill_addr;
  logic [TABLE_ADDR_BITS-1:0] idx_raw;
  logic                       tap_valid;
  logic [1:0]                 tap_quad;
  logic [WAVE_W-1:0]          tap_p16;
  logic                       tap_last;
  logic [SINE_W-1:0]          rom_word [TBL_N];

  // Quarter-sine contents, fixed at elaboration.
  for (genvar gi = 0; gi < TBL_N; gi++) begin : g_rom
    assign rom_word[gi] = sine_entry(gi, TABLE_ADDR_BITS);
  end

  // Handshake: the tap register must be free and the table filled.
  assign s1_free  = !tap_valid || st2_ready;
  assign in_ready = fill_done && s1_free;
  assign accept   = in_valid && in_ready;

  // A start restarts phase and frame count before this tick's sample.
  assign step_ext   = PHASE_BITS'(phase_step);
  assign phase_eff  = start_req ? '0 : phase_acc;
  assign frames_eff = start_req ? COUNT_BITS'(note_frames) : frames_left;
  assign produce    = (frames_eff != '0);

  // Table address: odd quadrants read the mirrored index.
  assign idx_raw   = phase_eff[PHASE_BITS-3 -: TABLE_ADDR_BITS];
  assign ram_raddr = phase_eff[PHASE_BITS-2] ? ~idx_raw : idx_raw;
  assign ram_re    = accept && produce;

  // Fill sweep writes one table entry per cycle after reset.
  assign ram_we    = !fill_done;
  assign ram_waddr = fill_addr;
  assign ram_wdata = rom_word[fill_addr];

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_done <= 1'b0;
      fill_addr <= '0;
    end else if (!fill_done) begin
      fill_addr <= fill_addr + 1'b1;
      if (fill_addr == TABLE_ADDR_BITS'(TBL_N - 1)) begin
        fill_done <= 1'b1;
      end
    end
  end

  // Phase accumulator and frame counter advance on each accepted tick that produces a sample.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_acc   <= '0;
      frames_left <= '0;
    end else if (accept) begin
      if (produce) begin
        phase_acc   <= phase_eff + step_ext;
        frames_left <= frames_eff - 1'b1;
      end else begin
        phase_acc   <= phase_eff;
        frames_left <= frames_eff;
      end
    end
  end

  // Tap register travels alongside the table read.
  always_ff @(posedge clk) begin
    if (rst) begin
      tap_valid <= 1'b0;
    end else if (s1_free) begin
      tap_valid <= accept && produce;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && produce) begin
      tap_quad <= phase_eff[PHASE_BITS-1 -: 2];
      tap_p16  <= phase_eff[PHASE_BITS-1 -: WAVE_W];
      tap_last <= (frames_eff == COUNT_BITS'(1));
    end
  end

  assign tap.valid = tap_valid;
  assign tap.quad  = tap_quad;
  assign tap.p16   = tap_p16;
  assign tap.last  = tap_last;

  // Checks.
  `MWTO_ASSERT_SAME(a_no_read_during_fill, clk, rst, !fill_done, !in_ready && !ram_re)
  `MWTO_ASSERT_NEXT(a_frames_count_down, clk, rst, accept && !start_req && frames_left != '0, frames_left == $past(frames_left) - COUNT_BITS'(1))
  `MWTO_ASSERT_NEXT(a_phase_advance, clk, rst, accept && !start_req && frames_left != '0, phase_acc == $past(phase_acc) + $past(step_ext))
  `MWTO_ASSERT_NEXT(a_tap_follows_read, clk, rst, ram_re, tap_valid)

endmodule

[sv/mwto_shaper.sv]
// ----------------------------------------------------------------------------
// mwto_shaper
// Waveform select, amplitude multiply, rounding and the output register.
// ----------------------------------------------------------------------------
module mwto_shaper
  import mwto_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  mwto_tap_t                     tap,
  input  logic [SINE_W-1:0]             rd_data,
  input  logic [AMP_W-1:0]              amplitude,
  input  wave_t                         waveform_select,
  output logic                          st2_ready,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] sample,
  output logic                          last
);

  localparam int SH = PROD_W - SAMPLE_BITS;
  localparam logic signed [31:0] RND    = 32'sd1 <<< (SH - 1);
  localparam logic signed [31:0] SMP_HI = (32'sd1 <<< (SAMPLE_BITS - 1)) - 32'sd1;
  localparam logic signed [31:0] SMP_LO = -(32'sd1 <<< (SAMPLE_BITS - 1));

  logic                     out_adv;
  logic                     v2;
  logic signed [PROD_W-1:0] prod;
  logic                     last2;
  logic signed [WAVE_W-1:0] p16;
  logic signed [WAVE_W-1:0] sine_val;
  logic signed [16:0]       mag;
  logic signed [17:0]       tri_val;
  logic signed [WAVE_W-1:0] wave;
  logic signed [31:0]       prod_full;
  logic signed [31:0]       rounded;
  logic signed [31:0]       clamped;

  assign out_adv   = !out_valid || out_ready;
  assign st2_ready = !v2 || out_adv;

  // Waveform value in Q1.15.
  assign p16      = $signed(tap.p16);
  assign sine_val = tap.quad[1] ? -$signed({1'b0, rd_data}) : $signed({1'b0, rd_data});
  assign mag      = p16[WAVE_W-1] ? -(17'(p16)) : 17'(p16);
  assign tri_val  = $signed({mag, 1'b0}) - 18'sd32768;

  always_comb begin
    case (waveform_select)
      WAVE_SINE:     wave = sine_val;
      WAVE_SQUARE:   wave = p16[WAVE_W-1] ? 16'sh8000 : 16'sh7fff;
      WAVE_SAW:      wave = p16;
      WAVE_TRIANGLE: wave = (tri_val > 18'sd32767) ? 16'sh7fff : tri_val[WAVE_W-1:0];
      default:       wave = p16;
    endcase
  end

  // Q1.15 times Q0.15 gives Q1.30.
  assign prod_full = 32'(wave) * 32'($signed({1'b0, amplitude}));

  // Half-up rounding to the sample width, then clamp.
  assign rounded = (32'(prod) + RND) >>> SH;
  always_comb begin
    if (rounded > SMP_HI) begin
      clamped = SMP_HI;
    end else if (rounded < SMP_LO) begin
      clamped = SMP_LO;
    end else begin
      clamped = rounded;
    end
  end

  // Stage valid flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (st2_ready) begin
        v2 <= tap.valid;
      end
      if (out_adv) begin
        out_valid <= v2;
      end
    end
  end

  // Product stage and output register payloads.
  always_ff @(posedge clk) begin
    if (st2_ready && tap.valid) begin
      prod  <= $signed(prod_full[PROD_W-1:0]);
      last2 <= tap.last;
    end
    if (out_adv && v2) begin
      sample <= clamped[SAMPLE_BITS-1:0];
      last   <= last2;
    end
  end

endmodule

[sv/multi_waveform_tone_oscillator.sv]
// ----------------------------------------------------------------------------
// multi_waveform_tone_oscillator
// Phase-accumulator tone generator with sine, square, saw and triangle output.
// ----------------------------------------------------------------------------
// Each accepted tick transaction yields one signed sample while the note lasts,
// the last one flagged, and nothing afterward until a tick with start_req set
// restarts the note at phase zero. The block takes one tick per cycle while
// in_ready is high; a sample passes through the table RAM read, the multiply
// stage and the output register. After reset the quarter-sine RAM is filled
// one entry per cycle, 2^TABLE_ADDR_BITS entries (256 by default), and in_ready
// stays low until the fill is done; configuration writes are taken throughout.
// ----------------------------------------------------------------------------
module multi_waveform_tone_oscillator
  import mwto_pkg::*;
#(
  parameter int PHASE_BITS      = PHASE_BITS_DEF,
  parameter int TABLE_ADDR_BITS = TABLE_ADDR_BITS_DEF,
  parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF,
  parameter int COUNT_BITS      = COUNT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          start_req,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] sample,
  output logic                          last
);

  logic [STEP_W-1:0]          phase_step;
  logic [AMP_W-1:0]           amplitude;
  wave_t                      waveform_select;
  logic [NOTE_W-1:0]          note_frames;
  logic                       st2_ready;
  mwto_tap_t                  tap;
  logic                       ram_we;
  logic [TABLE_ADDR_BITS-1:0] ram_waddr;
  logic [SINE_W-1:0]          ram_wdata;
  logic                       ram_re;
  logic [TABLE_ADDR_BITS-1:0] ram_raddr;
  logic [SINE_W-1:0]          ram_rdata;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step      <= '0;
      amplitude       <= '0;
      waveform_select <= WAVE_SINE;
      note_frames     <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index_t'(cfg_index))
        REG_PHASE_STEP:  phase_step      <= cfg_data[STEP_W-1:0];
        REG_AMPLITUDE:   amplitude       <= cfg_data[AMP_W-1:0];
        REG_WAVEFORM:    waveform_select <= wave_t'(cfg_data[1:0]);
        REG_NOTE_FRAMES: note_frames     <= cfg_data[NOTE_W-1:0];
        default:         phase_step      <= phase_step;
      endcase
    end
  end

  // Phase and frame bookkeeping, table read issue.
  mwto_phase #(
    .PHASE_BITS      (PHASE_BITS),
    .TABLE_ADDR_BITS (TABLE_ADDR_BITS),
    .COUNT_BITS      (COUNT_BITS)
  ) u_phase (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .start_req   (start_req),
    .phase_step  (phase_step),
    .note_frames (note_frames),
    .st2_ready   (st2_ready),
    .tap         (tap),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .ram_re      (ram_re),
    .ram_raddr   (ram_raddr)
  );

  // Quarter-sine table.
  mwto_ram #(
    .WIDTH (SINE_W),
    .DEPTH (1 << TABLE_ADDR_BITS)
  ) u_sine_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Waveform shaping, scaling and output register.
  mwto_shaper #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_shaper (
    .clk             (clk),
    .rst             (rst),
    .tap             (tap),
    .rd_data         (ram_rdata),
    .amplitude       (amplitude),
    .waveform_select (waveform_select),
    .st2_ready       (st2_ready),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .sample          (sample),
    .last            (last)
  );

endmodule

[tb/sv/tb_multi_waveform_tone_oscillator.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_multi_waveform_tone_oscillator
// Self-checking bench for the tone oscillator. A short scripted sequence
// covers the waveform extremes, zero-length notes and restarts. Random
// setting phases then drive tick transactions with random gaps on both
// sides. Samples are checked against scripted values or a local NCO predictor.
// ----------------------------------------------------------------------------
module tb_multi_waveform_tone_oscillator;
  import mwto_pkg::*;

  localparam int SMP_W          = SAMPLE_BITS_DEF;
  localparam int ADDR_W         = TABLE_ADDR_BITS_DEF;
  localparam int ROM_DEPTH      = 1 << ADDR_W;
  localparam int PH_W           = PHASE_BITS_DEF;
  localparam int CNT_W          = COUNT_BITS_DEF;
  localparam int SCALE_SHIFT    = 31 - SMP_W;
  localparam int DRAIN_CYCLES   = 8;
  localparam int MAX_GAP        = 4;
  localparam int HOLD_CYCLES    = 80;
  localparam int TOTAL_TICKS    = 1250;
  localparam int PRESSURE_PHASE = 2;
  localparam int LIMIT_CYCLES   = 400000;

  typedef enum {ROW_CFG, ROW_PREDICT, ROW_TYPED, ROW_SILENT} row_kind_t;

  typedef struct {
    row_kind_t               kind;
    cfg_index_t              sel;
    logic [CFG_DATA_W-1:0]   data;
    logic                    start;
    logic signed [SMP_W-1:0] smp;
    logic                    lst;
  } script_row_t;

  typedef struct {
    logic signed [SMP_W-1:0] smp;
    logic                    lst;
  } tone_sample_t;

  // DUT connections, all inputs known from time zero.
  logic                    clk       = 1'b0;
  logic                    rst       = 1'b1;
  logic                    cfg_wr_en = 1'b0;
  logic [CFG_INDEX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0]   cfg_data  = '0;
  logic                    in_valid  = 1'b0;
  logic                    in_ready;
  logic                    start_req = 1'b0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic signed [SMP_W-1:0] sample;
  logic                    last;

  // Predictor state and its copy of the settings.
  logic [PH_W-1:0]         osc_phase  = '0;
  logic [CNT_W-1:0]        osc_frames = '0;
  logic [STEP_W-1:0]       set_step   = '0;
  logic [AMP_W-1:0]        set_gain   = '0;
  wave_t                   set_wave   = WAVE_SINE;
  logic [NOTE_W-1:0]       set_note   = '0;
  logic [SINE_W-1:0]       sine_rom [ROM_DEPTH];

  tone_sample_t            expected_samples [$];
  bit                      sender_no_idle   = 1'b0;
  bit                      receiver_no_idle = 1'b0;
  bit                      hold_pending     = 1'b0;
  int                      mismatch_count   = 0;
  int                      samples_checked  = 0;
  int                      samples_predicted = 0;
  int                      ticks_sent       = 0;
  int                      notes_started    = 0;
  int                      cycle_count      = 0;

  multi_waveform_tone_oscillator dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .start_req (start_req),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sample    (sample),
    .last      (last)
  );

  // 2 ns clock.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Run-away guard.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("%0t: timeout with %0d samples outstanding", $time, expected_samples.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  // Quarter-wave entry at the bin center, Q30 Taylor series to x^13.
  function automatic logic [SINE_W-1:0] quarter_sine(input int unsigned i);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] term;
    logic [63:0] s;
    logic [63:0] e;
    int unsigned n;
    x  = (HALF_PI_Q30 * (64'(i) * 64'd2 + 64'd1)) / 64'(2 * ROM_DEPTH);
    x2 = (x * x) >> 30;
    t  = Q30_ONE;
    // Divisors run 13*12, 11*10, ... down to 3*2.
    for (int k = 0; k < 6; k++) begin
      n    = 12 - 2 * k;
      term = ((x2 * t) >> 30) / 64'(n * (n + 1));
      t    = (term >= Q30_ONE) ? 64'd0 : Q30_ONE - term;
    end
    s = (x * t) >> 30;
    e = (s * 64'd32767 + (64'd1 << 29)) >> 30;
    return (e > 64'd32767) ? 15'h7fff : e[SINE_W-1:0];
  endfunction

  // Raw Q1.15 waveform value at a phase.
  function automatic int waveform_at(input logic [PH_W-1:0] ph);
    logic [15:0]       top;
    logic [ADDR_W-1:0] idx;
    int                p16;
    int                mag;
    int                w;
    top = ph[PH_W-1 -: 16];
    p16 = $signed(top);
    case (set_wave)
      WAVE_SINE: begin
        idx = ph[PH_W-3 -: ADDR_W];
        // Odd quadrants walk the table backward, the lower half negates.
        if (ph[PH_W-2]) idx = ~idx;
        mag = sine_rom[idx];
        w   = ph[PH_W-1] ? -mag : mag;
      end
      WAVE_SQUARE: w = ph[PH_W-1] ? -32768 : 32767;
      WAVE_SAW:    w = p16;
      default: begin
        mag = (p16 < 0) ? -p16 : p16;
        w   = 2 * mag - 32768;
        if (w > 32767) w = 32767;
      end
    endcase
    return w;
  endfunction

  // Gain scaling with half-up rounding and saturation.
  function automatic logic signed [SMP_W-1:0] scale_to_sample(input int w);
    longint prod;
    longint r;
    prod = longint'(w) * longint'(set_gain);
    r    = (prod + (longint'(1) << (SCALE_SHIFT - 1))) >>> SCALE_SHIFT;
    if (r > (longint'(1) << (SMP_W - 1)) - 1) r = (longint'(1) << (SMP_W - 1)) - 1;
    if (r < -(longint'(1) << (SMP_W - 1))) r = -(longint'(1) << (SMP_W - 1));
    return r[SMP_W-1:0];
  endfunction

  // Advance the oscillator by one tick; returns 1 when a sample comes out.
  function automatic bit tone_predict(input logic start, output tone_sample_t res);
    if (start) begin
      osc_phase  = '0;
      osc_frames = set_note;
    end
    if (osc_frames == 0) return 1'b0;
    res.smp    = scale_to_sample(waveform_at(osc_phase));
    osc_frames = osc_frames - 1'b1;
    res.lst    = (osc_frames == 0);
    osc_phase  = osc_phase + set_step;
    return 1'b1;
  endfunction

  function automatic script_row_t cfg_row(input cfg_index_t sel, input logic [31:0] data);
    script_row_t row;
    row       = '{ROW_CFG, sel, data, 1'b0, '0, 1'b0};
    return row;
  endfunction

  function automatic script_row_t tick_row(input logic start, input row_kind_t kind,
                                           input logic signed [SMP_W-1:0] smp,
                                           input logic lst);
    script_row_t row;
    row = '{kind, REG_PHASE_STEP, '0, start, smp, lst};
    return row;
  endfunction

  // One register write; the enable is left high for the caller to drop.
  task automatic cfg_write(input cfg_index_t sel, input logic [CFG_DATA_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= data;
    @(negedge clk);
    case (sel)
      REG_PHASE_STEP:  set_step = data[STEP_W-1:0];
      REG_AMPLITUDE:   set_gain = data[AMP_W-1:0];
      REG_WAVEFORM:    set_wave = wave_t'(data[1:0]);
      REG_NOTE_FRAMES: set_note = data[NOTE_W-1:0];
      default: ;
    endcase
  endtask

  // Hold the input until every sample is back and the pipeline has drained.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_samples.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Offer one tick transaction and log the sample it should produce.
  task automatic send_tick(input logic start, input row_kind_t kind,
                           input logic signed [SMP_W-1:0] typed_smp,
                           input logic typed_lst);
    int           gap;
    bit           has;
    tone_sample_t res;
    gap = sender_no_idle ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    start_req <= start;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    has = tone_predict(start, res);
    ticks_sent++;
    if (start) notes_started++;
    if (has) samples_predicted++;
    if (kind == ROW_TYPED) begin
      res.smp = typed_smp;
      res.lst = typed_lst;
      expected_samples.insert(expected_samples.size(), res);
    end else if (kind == ROW_PREDICT && has) begin
      expected_samples.insert(expected_samples.size(), res);
    end
    @(negedge clk);
  endtask

  // Sample sink: random back-pressure, one long hold on request.
  initial begin : sample_sink
    int           gap;
    tone_sample_t want;
    @(negedge rst);
    forever begin
      if (hold_pending) begin
        gap          = HOLD_CYCLES;
        hold_pending = 1'b0;
      end else begin
        gap = receiver_no_idle ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      samples_checked++;
      if (expected_samples.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected sample, expected none, got %0d last %0b",
                 $time, sample, last);
      end else begin
        want = expected_samples.pop_front();
        if (sample !== want.smp) begin
          mismatch_count++;
          $display("%0t: sample mismatch, expected %0d, got %0d", $time, want.smp, sample);
        end
        if (last !== want.lst) begin
          mismatch_count++;
          $display("%0t: last mismatch, expected %0b, got %0b", $time, want.lst, last);
        end
      end
      @(negedge clk);
    end
  end

  // Stimulus: scripted part, then random setting phases.
  initial begin : tick_source
    script_row_t       script [$];
    bit                prev_cfg;
    bit                wrote;
    bit                pressure;
    logic              start;
    logic [31:0]       d;
    int                n_items;
    int                phase_idx;

    for (int i = 0; i < ROM_DEPTH; i++) sine_rom[i] = quarter_sine(i);

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // With every register at reset, ticks and starts yield nothing.
    script.insert(script.size(), tick_row(1'b0, ROW_SILENT, '0, 1'b0));
    script.insert(script.size(), tick_row(1'b1, ROW_SILENT, '0, 1'b0));
    // Full-scale square at a standing phase, three-sample note.
    script.insert(script.size(), cfg_row(REG_AMPLITUDE, 32'd32767));
    script.insert(script.size(), cfg_row(REG_WAVEFORM, 32'(WAVE_SQUARE)));
    script.insert(script.size(), cfg_row(REG_PHASE_STEP, 32'd0));
    script.insert(script.size(), cfg_row(REG_NOTE_FRAMES, 32'd3));
    script.insert(script.size(), tick_row(1'b1, ROW_TYPED, 16'sd32766, 1'b0));
    script.insert(script.size(), tick_row(1'b0, ROW_TYPED, 16'sd32766, 1'b0));
    script.insert(script.size(), tick_row(1'b0, ROW_TYPED, 16'sd32766, 1'b1));
    script.insert(script.size(), tick_row(1'b0, ROW_SILENT, '0, 1'b0));
    // Half-cycle step flips the square; a restart mid-note drops its last flag.
    script.insert(script.size(), cfg_row(REG_PHASE_STEP, 32'h8000_0000));
    script.insert(script.size(), cfg_row(REG_NOTE_FRAMES, 32'd4));
    script.insert(script.size(), tick_row(1'b1, ROW_TYPED, 16'sd32766, 1'b0));
    script.insert(script.size(), tick_row(1'b0, ROW_TYPED, -16'sd32767, 1'b0));
    script.insert(script.size(), tick_row(1'b1, ROW_TYPED, 16'sd32766, 1'b0));
    script.insert(script.size(), tick_row(1'b0, ROW_TYPED, -16'sd32767, 1'b0));
    script.insert(script.size(), tick_row(1'b0, ROW_TYPED, 16'sd32766, 1'b0));
    script.insert(script.size(), tick_row(1'b0, ROW_TYPED, -16'sd32767, 1'b1));
    // Saw and triangle at phase zero and one half.
    script.insert(script.size(), cfg_row(REG_WAVEFORM, 32'(WAVE_SAW)));
    script.insert(script.size(), cfg_row(REG_NOTE_FRAMES, 32'd2));
    script.insert(script.size(), tick_row(1'b1, ROW_TYPED, 16'sd0, 1'b0));
    script.insert(script.size(), tick_row(1'b0, ROW_TYPED, -16'sd32767, 1'b1));
    script.insert(script.size(), cfg_row(REG_WAVEFORM, 32'(WAVE_TRIANGLE)));
    script.insert(script.size(), tick_row(1'b1, ROW_TYPED, -16'sd32767, 1'b0));
    script.insert(script.size(), tick_row(1'b0, ROW_TYPED, 16'sd32766, 1'b1));
    // Zero gain silences the waveform but keeps the samples coming.
    script.insert(script.size(), cfg_row(REG_AMPLITUDE, 32'd0));
    script.insert(script.size(), tick_row(1'b1, ROW_TYPED, 16'sd0, 1'b0));
    script.insert(script.size(), tick_row(1'b0, ROW_TYPED, 16'sd0, 1'b1));
    // Sine with the largest step over the longest note.
    script.insert(script.size(), cfg_row(REG_WAVEFORM, 32'(WAVE_SINE)));
    script.insert(script.size(), cfg_row(REG_AMPLITUDE, 32'd32767));
    script.insert(script.size(), cfg_row(REG_PHASE_STEP, 32'hFFFF_FFFF));
    script.insert(script.size(), cfg_row(REG_NOTE_FRAMES, 32'h00FF_FFFF));
    script.insert(script.size(), tick_row(1'b1, ROW_PREDICT, '0, 1'b0));
    script.insert(script.size(), tick_row(1'b0, ROW_PREDICT, '0, 1'b0));
    script.insert(script.size(), tick_row(1'b0, ROW_PREDICT, '0, 1'b0));
    // Step change while the note runs, then out-of-width register data.
    script.insert(script.size(), cfg_row(REG_PHASE_STEP, 32'h0100_0000));
    script.insert(script.size(), tick_row(1'b0, ROW_PREDICT, '0, 1'b0));
    script.insert(script.size(), tick_row(1'b0, ROW_PREDICT, '0, 1'b0));
    script.insert(script.size(), cfg_row(REG_AMPLITUDE, 32'hFFFF_FFFF));
    script.insert(script.size(), cfg_row(REG_WAVEFORM, 32'hFFFF_FFFD));
    script.insert(script.size(), tick_row(1'b0, ROW_PREDICT, '0, 1'b0));
    script.insert(script.size(), tick_row(1'b1, ROW_PREDICT, '0, 1'b0));

    // Walk the script; writes only go in once the block is idle.
    prev_cfg = 1'b0;
    foreach (script[r]) begin
      if (script[r].kind == ROW_CFG) begin
        if (!prev_cfg) wait_idle();
        cfg_write(script[r].sel, script[r].data);
        prev_cfg = 1'b1;
      end else begin
        if (prev_cfg) cfg_wr_en <= 1'b0;
        prev_cfg = 1'b0;
        send_tick(script[r].start, script[r].kind, script[r].smp, script[r].lst);
      end
    end
    wait_idle();

    // Random phases: new settings, then a burst of ticks with sparse restarts.
    phase_idx = 0;
    while (ticks_sent < TOTAL_TICKS) begin
      pressure = (phase_idx == PRESSURE_PHASE);
      wrote    = 1'b0;
      for (int r = 0; r < 4; r++) begin
        if (pressure || $urandom_range(0, 3) != 0) begin
          case (cfg_index_t'(r))
            REG_PHASE_STEP: begin
              case ($urandom_range(0, 5))
                0:       d = 32'h0000_0000;
                1:       d = 32'hFFFF_FFFF;
                2:       d = 32'h8000_0000;
                3:       d = $urandom_range(1, 1 << 20);
                default: d = $urandom;
              endcase
            end
            REG_AMPLITUDE: begin
              case ($urandom_range(0, 3))
                0:       d = $urandom & ~32'h0000_7FFF;
                1:       d = $urandom | 32'h0000_7FFF;
                default: d = $urandom;
              endcase
            end
            REG_WAVEFORM: d = $urandom;
            default: begin
              case ($urandom_range(0, 11))
                0:       d = $urandom & 32'hFF00_0000;
                1:       d = ($urandom & 32'hFF00_0000) | 32'd1;
                2:       d = $urandom | 32'h00FF_FFFF;
                default: d = ($urandom & 32'hFF00_0000) | $urandom_range(2, 40);
              endcase
              // A long note keeps the pipeline busy through the sink's hold.
              if (pressure) d = 32'd600;
            end
          endcase
          cfg_write(cfg_index_t'(r), d);
          wrote = 1'b1;
        end
      end
      if (wrote) cfg_wr_en <= 1'b0;

      sender_no_idle   = pressure || (phase_idx % 5 == 4);
      receiver_no_idle = (phase_idx % 5 == 4);
      if (pressure) hold_pending = 1'b1;
      n_items = pressure ? 150 : $urandom_range(40, 60);

      for (int i = 0; i < n_items; i++) begin
        if (i == 0) start = pressure || ($urandom_range(0, 3) != 0);
        else start = !pressure && ($urandom_range(0, 15) == 0);
        send_tick(start, ROW_PREDICT, '0, 1'b0);
      end
      wait_idle();
      phase_idx++;
    end

    $display("Checked %0d samples (%0d predicted) from %0d ticks, %0d note starts, %0d phases.",
             samples_checked, samples_predicted, ticks_sent, notes_started, phase_idx);
    $display("Covered all waveforms, extreme steps and gains, empty and restarted notes.");
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
